/* rtl/crs_pkg.sv */
// ----------------------------------------------------------------------------
// crs_pkg
// Types and constants shared by the CRS pilot generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_CELL_ID      = 2'd0;
    localparam logic [1:0] REG_NUM_RB       = 2'd1;
    localparam logic [1:0] REG_NORMAL_CP    = 2'd2;
    localparam logic [1:0] REG_ANTENNA_PORT = 2'd3;

    localparam logic [8:0] CELL_ID_RST      = 9'd0;
    localparam logic [6:0] NUM_RB_RST       = 7'd6;
    localparam logic       NORMAL_CP_RST    = 1'b1;
    localparam logic [1:0] ANTENNA_PORT_RST = 2'd0;

    localparam logic [8:0] CELL_ID_MAX = 9'd503;
    localparam logic [6:0] NUM_RB_MIN  = 7'd6;
    localparam logic [4:0] SLOT_MAX    = 5'd19;

    localparam logic [3:0] NSYMB_NORMAL = 4'd7;
    localparam logic [3:0] NSYMB_EXT    = 4'd6;

    localparam logic signed [15:0] PILOT_AMP = 16'sd23170;

    typedef struct packed {
        logic [8:0] cell_id;
        logic [6:0] num_rb;
        logic       normal_cp;
        logic [1:0] antenna_port;
    } crs_cfg_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic load;
        logic step;
        logic sample_i;
        logic sample_q;
        logic emit;
    } crs_cmd_t;

    typedef struct packed {
        logic bad;
        logic run_done;
        logic out_free;
    } crs_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_RUN,
        ST_SAMPLE_Q,
        ST_WRITE
    } crs_state_t;

    // x mod 6 via reciprocal 171/1024, exact for 9-bit x
    function automatic logic [2:0] mod6(input logic [8:0] x);
        logic [16:0] prod;
        logic [6:0]  q;
        logic [8:0]  r;
        prod = 17'(x) * 17'd171;
        q    = prod[16:10];
        r    = x - 9'(q) * 9'd6;
        if (r >= 9'd6)
        begin
            r = r - 9'd6;
        end
        return r[2:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/crs_if.sv */
// ----------------------------------------------------------------------------
// crs_if
// Valid/ready channels for pilot requests and pilot results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crs_req_if;
    logic       valid;
    logic       ready;
    logic [4:0] slot;
    logic       sym_sel;
    logic [7:0] pair_index;

    modport source (output valid, output slot, output sym_sel, output pair_index,
                    input ready);
    modport sink (input valid, input slot, input sym_sel, input pair_index,
                  output ready);
endinterface

interface crs_pilot_if;
    logic               valid;
    logic               ready;
    logic [3:0]         ofdm_symbol;
    logic [10:0]        subcarrier;
    logic signed [15:0] pilot_i;
    logic signed [15:0] pilot_q;
    logic               status;

    modport source (output valid, output ofdm_symbol, output subcarrier,
                    output pilot_i, output pilot_q, output status, input ready);
    modport sink (input valid, input ofdm_symbol, input subcarrier,
                  input pilot_i, input pilot_q, input status, output ready);
endinterface

`default_nettype wire

/* rtl/crs_regs.sv */
// ----------------------------------------------------------------------------
// crs_regs
// APB configuration registers: cell id, RB count, CP mode, antenna port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crs_regs
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [crs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [crs_pkg::DATA_W-1:0] pwdata,
    output logic      [crs_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output crs_pkg::crs_cfg_t               cfg
);

    crs_pkg::crs_cfg_t cfg_reg;
    logic [1:0]        index;
    logic              wr_en;

    assign index  = paddr[3:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_id      <= crs_pkg::CELL_ID_RST;
            cfg_reg.num_rb       <= crs_pkg::NUM_RB_RST;
            cfg_reg.normal_cp    <= crs_pkg::NORMAL_CP_RST;
            cfg_reg.antenna_port <= crs_pkg::ANTENNA_PORT_RST;
        end
        else if (wr_en)
        begin
            case (index)
                crs_pkg::REG_CELL_ID:      cfg_reg.cell_id      <= pwdata[8:0];
                crs_pkg::REG_NUM_RB:       cfg_reg.num_rb       <= pwdata[6:0];
                crs_pkg::REG_NORMAL_CP:    cfg_reg.normal_cp    <= pwdata[0];
                crs_pkg::REG_ANTENNA_PORT: cfg_reg.antenna_port <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            crs_pkg::REG_CELL_ID:      prdata = crs_pkg::DATA_W'(cfg_reg.cell_id);
            crs_pkg::REG_NUM_RB:       prdata = crs_pkg::DATA_W'(cfg_reg.num_rb);
            crs_pkg::REG_NORMAL_CP:    prdata = crs_pkg::DATA_W'(cfg_reg.normal_cp);
            crs_pkg::REG_ANTENNA_PORT: prdata = crs_pkg::DATA_W'(cfg_reg.antenna_port);
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/crs_ctrl.sv */
// ----------------------------------------------------------------------------
// crs_ctrl
// Request sequencer: setup, seed load, Gold run, sampling and result write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crs_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire crs_pkg::crs_stat_t stat,
    output crs_pkg::crs_cmd_t       cmd
);

    crs_pkg::crs_state_t state_reg;
    crs_pkg::crs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            crs_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = crs_pkg::ST_SETUP;
                end
            end
            crs_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = crs_pkg::ST_LOAD;
            end
            crs_pkg::ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = stat.bad ? crs_pkg::ST_WRITE : crs_pkg::ST_RUN;
            end
            crs_pkg::ST_RUN:
            begin
                if (stat.run_done)
                begin
                    cmd.sample_i = 1'b1;
                    state_next   = crs_pkg::ST_SAMPLE_Q;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            crs_pkg::ST_SAMPLE_Q:
            begin
                cmd.sample_q = 1'b1;
                state_next   = crs_pkg::ST_WRITE;
            end
            crs_pkg::ST_WRITE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = crs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = crs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/crs_datapath.sv */
// ----------------------------------------------------------------------------
// crs_datapath
// Request checks, seed product, Gold LFSR pair, step counter, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crs_datapath
#(
    parameter int MAX_RB    = 110,
    parameter int GOLD_SKIP = 1600
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire crs_pkg::crs_cfg_t        cfg,
    input  wire crs_pkg::crs_cmd_t        cmd,
    output crs_pkg::crs_stat_t            stat,
    input  wire logic [4:0]               in_slot,
    input  wire logic                     in_sym_sel,
    input  wire logic [7:0]               in_pair_index,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [3:0]                    out_ofdm_symbol,
    output logic [10:0]                   out_subcarrier,
    output logic signed [15:0]            out_pilot_i,
    output logic signed [15:0]            out_pilot_q,
    output logic                          out_status
);

    localparam int STEP_MAX = GOLD_SKIP + 4 * MAX_RB;
    localparam int CNT_W    = $clog2(STEP_MAX + 1);
    localparam logic [6:0]       RB_MAX_C  = 7'(MAX_RB);
    localparam logic [CNT_W-1:0] MAX_RB_W  = CNT_W'(MAX_RB);
    localparam logic [CNT_W-1:0] SKIP_W    = CNT_W'(GOLD_SKIP);

    // captured request
    logic [4:0]  slot_reg;
    logic        sel_reg;
    logic [7:0]  m_reg;

    // setup results
    logic             bad_reg;
    logic [3:0]       ofdm_reg;
    logic [10:0]      sc_reg;
    logic [CNT_W-1:0] total_reg;
    logic [17:0]      prod_reg;

    // Gold sequence
    logic [30:0]      x1_reg;
    logic [30:0]      x2_reg;
    logic [30:0]      x1_next;
    logic [30:0]      x2_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             ci_reg;
    logic             cq_reg;

    // output register
    logic               out_valid_reg;
    logic [3:0]         ofdm_out_reg;
    logic [10:0]        sc_out_reg;
    logic signed [15:0] pi_out_reg;
    logic signed [15:0] pq_out_reg;
    logic               status_out_reg;

    // setup logic
    logic        bad;
    logic [3:0]  nsymb;
    logic [2:0]  l;
    logic [2:0]  v;
    logic [3:0]  vsum;
    logic [2:0]  shift;
    logic [3:0]  ofdm;
    logic [10:0] sc;
    logic [7:0]  a;
    logic [CNT_W-1:0] mp;

    always_comb
    begin
        nsymb = cfg.normal_cp ? crs_pkg::NSYMB_NORMAL : crs_pkg::NSYMB_EXT;
        bad   = (slot_reg > crs_pkg::SLOT_MAX) || (cfg.cell_id > crs_pkg::CELL_ID_MAX) ||
                (cfg.num_rb < crs_pkg::NUM_RB_MIN) || (cfg.num_rb > RB_MAX_C) ||
                (m_reg >= {cfg.num_rb, 1'b0}) || (sel_reg && cfg.antenna_port[1]);
        if (cfg.antenna_port[1])
        begin
            l = 3'd1;
        end
        else
        begin
            l = sel_reg ? 3'(nsymb - 4'd3) : 3'd0;
        end
        case (cfg.antenna_port)
            2'd0:    v = (l == 3'd0) ? 3'd0 : 3'd3;
            2'd1:    v = (l == 3'd0) ? 3'd3 : 3'd0;
            2'd2:    v = slot_reg[0] ? 3'd3 : 3'd0;
            default: v = slot_reg[0] ? 3'd6 : 3'd3;
        endcase
        vsum = 4'(v) + 4'(crs_pkg::mod6(cfg.cell_id));
        if (vsum >= 4'd6)
        begin
            vsum = vsum - 4'd6;
        end
        shift = vsum[2:0];
        ofdm  = (slot_reg[0] ? nsymb : 4'd0) + 4'(l);
        sc    = 11'({m_reg, 2'b00}) + 11'({m_reg, 1'b0}) + 11'(shift);
        a     = 8'(7 * (int'(slot_reg) + 1)) + 8'(l) + 8'd1;
        mp    = CNT_W'(m_reg) + MAX_RB_W - CNT_W'(cfg.num_rb);
    end

    assign x1_next = {x1_reg[0] ^ x1_reg[3], x1_reg[30:1]};
    assign x2_next = {x2_reg[0] ^ x2_reg[1] ^ x2_reg[2] ^ x2_reg[3], x2_reg[30:1]};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg <= in_slot;
            sel_reg  <= in_sym_sel;
            m_reg    <= in_pair_index;
        end
        if (cmd.setup)
        begin
            bad_reg   <= bad;
            ofdm_reg  <= ofdm;
            sc_reg    <= sc;
            total_reg <= SKIP_W + {mp[CNT_W-2:0], 1'b0};
            prod_reg  <= 18'(a) * 18'({cfg.cell_id, 1'b1});
        end
        if (cmd.load)
        begin
            x1_reg  <= 31'd1;
            x2_reg  <= 31'({prod_reg, cfg.cell_id, cfg.normal_cp});
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            x1_reg  <= x1_next;
            x2_reg  <= x2_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.sample_i)
        begin
            ci_reg <= x1_reg[0] ^ x2_reg[0];
            x1_reg <= x1_next;
            x2_reg <= x2_next;
        end
        else if (cmd.sample_q)
        begin
            cq_reg <= x1_reg[0] ^ x2_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (bad_reg)
            begin
                ofdm_out_reg   <= '0;
                sc_out_reg     <= '0;
                pi_out_reg     <= '0;
                pq_out_reg     <= '0;
                status_out_reg <= 1'b1;
            end
            else
            begin
                ofdm_out_reg   <= ofdm_reg;
                sc_out_reg     <= sc_reg;
                pi_out_reg     <= ci_reg ? -crs_pkg::PILOT_AMP : crs_pkg::PILOT_AMP;
                pq_out_reg     <= cq_reg ? -crs_pkg::PILOT_AMP : crs_pkg::PILOT_AMP;
                status_out_reg <= 1'b0;
            end
        end
    end

    assign stat.bad      = bad_reg;
    assign stat.run_done = (cnt_reg == total_reg);
    assign stat.out_free = ~out_valid_reg | out_ready;

    assign out_valid       = out_valid_reg;
    assign out_ofdm_symbol = ofdm_out_reg;
    assign out_subcarrier  = sc_out_reg;
    assign out_pilot_i     = pi_out_reg;
    assign out_pilot_q     = pq_out_reg;
    assign out_status      = status_out_reg;

endmodule

`default_nettype wire

/* rtl/lte_crs_pilot_generator.sv */
// ----------------------------------------------------------------------------
// lte_crs_pilot_generator
// LTE cell-specific reference signal pilot generator, one pilot per request.
//
// Usage:
//   req   : valid/ready request channel (slot, sym_sel, pair_index). A transfer
//           takes place when valid and ready are both high.
//   pilot : valid/ready result channel (ofdm_symbol, subcarrier, pilot_i,
//           pilot_q, status), one result per request, held in an output
//           register until the receiver takes it.
//   APB   : cell_id at 0x0, num_rb at 0x4, normal_cp at 0x8, antenna_port
//           at 0xC; write only while no request is in flight.
// Sequence: after a request transfer the single Gold LFSR pair is seeded and
//   steps GOLD_SKIP + 2*m' times, with m' = pair_index + MAX_RB - num_rb,
//   before the I and Q bits are sampled. An out-of-range request skips the
//   Gold run and returns status 1. A new request is taken only once the
//   previous result is written to the output register, so requests do not
//   overlap.
// Reset: rst_n clears the sequencer, the result valid and the configuration
//   registers to their defaults. A stalled receiver holds the result; the
//   block then waits with the next result until the output register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lte_crs_pilot_generator
#(
    parameter int MAX_RB    = 110,
    parameter int GOLD_SKIP = 1600
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    crs_req_if.sink                         req,
    crs_pilot_if.source                     pilot,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [crs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [crs_pkg::DATA_W-1:0] pwdata,
    output logic      [crs_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);

    crs_pkg::crs_cfg_t  cfg;
    crs_pkg::crs_cmd_t  cmd;
    crs_pkg::crs_stat_t stat;

    crs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    crs_datapath
    #(
        .MAX_RB    (MAX_RB),
        .GOLD_SKIP (GOLD_SKIP)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .in_slot         (req.slot),
        .in_sym_sel      (req.sym_sel),
        .in_pair_index   (req.pair_index),
        .out_valid       (pilot.valid),
        .out_ready       (pilot.ready),
        .out_ofdm_symbol (pilot.ofdm_symbol),
        .out_subcarrier  (pilot.subcarrier),
        .out_pilot_i     (pilot.pilot_i),
        .out_pilot_q     (pilot.pilot_q),
        .out_status      (pilot.status)
    );

endmodule

`default_nettype wire

/* sim/lte_crs_pilot_generator_tb.sv */
// ----------------------------------------------------------------------------
// lte_crs_pilot_generator_tb
// Self-checking bench for the CRS pilot generator. A driver and a monitor,
// both clocked processes, move requests and pilots over valid/ready channels
// with random gaps. Each accepted request is run through a local Gold
// sequence predictor. Each pilot is compared field by field with the oldest
// prediction. Register settings change between phases over APB, with the
// block idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lte_crs_pilot_generator_tb;

    localparam int MAX_RB       = 110;
    localparam int GOLD_SKIP    = 1600;
    localparam int HOLD_CYCLES  = 4000;
    localparam int STALL_LIMIT  = 30000;
    localparam int DRAIN_CYCLES = 2100;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 29;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic [4:0] slot;
        logic       sym_sel;
        logic [7:0] pair_index;
    } pilot_req_t;

    typedef struct packed {
        logic [3:0]         ofdm_symbol;
        logic [10:0]        subcarrier;
        logic signed [15:0] pilot_i;
        logic signed [15:0] pilot_q;
        logic               status;
    } pilot_res_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [crs_pkg::ADDR_W-1:0] paddr;
    logic [crs_pkg::DATA_W-1:0] pwdata;
    logic [crs_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    crs_req_if   req_bus ();
    crs_pilot_if pilot_bus ();

    lte_crs_pilot_generator
    #(
        .MAX_RB    (MAX_RB),
        .GOLD_SKIP (GOLD_SKIP)
    )
    dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .pilot   (pilot_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    crs_pkg::crs_cfg_t cfg_shadow;
    pilot_req_t req_items[$];
    pilot_res_t pilot_expected[$];
    pilot_res_t rx_want;
    int         mismatch_count = 0;
    int         rx_count = 0;
    int         req_gap = 0;
    int         rx_gap = 0;
    int         hold_left;
    int         hold_seen = 0;
    int         idle_cycles;
    bit         no_idle = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic log_mismatch(input string msg);
        $display("mismatch at pilot %0d: %s", rx_count, msg);
        mismatch_count++;
    endtask

    function automatic pilot_res_t predict_pilot(crs_pkg::crs_cfg_t cfg, pilot_req_t rq);
        pilot_res_t  res;
        int unsigned nsymb, l, v, shift, c_init, steps, n;
        int unsigned slot_n, m, cell_n, nrb, port;
        logic [30:0] x1, x2;
        logic        ci;
        logic        cq;
        res    = '0;
        ci     = 1'b0;
        slot_n = rq.slot;
        m      = rq.pair_index;
        cell_n = cfg.cell_id;
        nrb    = cfg.num_rb;
        port   = cfg.antenna_port;
        if (slot_n > crs_pkg::SLOT_MAX || cell_n > crs_pkg::CELL_ID_MAX
            || nrb < crs_pkg::NUM_RB_MIN || nrb > MAX_RB
            || m >= 2 * nrb || (rq.sym_sel && port >= 2))
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        nsymb = cfg.normal_cp ? crs_pkg::NSYMB_NORMAL : crs_pkg::NSYMB_EXT;
        if (port >= 2)
            l = 1;
        else
            l = rq.sym_sel ? nsymb - 3 : 0;
        case (port)
            0:       v = (l == 0) ? 0 : 3;
            1:       v = (l == 0) ? 3 : 0;
            2:       v = 3 * rq.slot[0];
            default: v = 3 + 3 * rq.slot[0];
        endcase
        shift  = (v + cell_n % 6) % 6;
        c_init = 1024 * (7 * (slot_n + 1) + l + 1) * (2 * cell_n + 1) + 2 * cell_n
                 + cfg.normal_cp;
        x1     = 31'd1;
        x2     = c_init[30:0];
        steps  = GOLD_SKIP + 2 * (m + MAX_RB - nrb);
        for (n = 0; n <= steps; n++)
        begin
            if (n == steps)
                ci = x1[0] ^ x2[0];
            x1 = {x1[0] ^ x1[3], x1[30:1]};
            x2 = {^x2[3:0], x2[30:1]};
        end
        cq = x1[0] ^ x2[0];
        res.ofdm_symbol = 4'(rq.slot[0] * nsymb + l);
        res.subcarrier  = 11'(6 * m + shift);
        res.pilot_i     = ci ? -crs_pkg::PILOT_AMP : crs_pkg::PILOT_AMP;
        res.pilot_q     = cq ? -crs_pkg::PILOT_AMP : crs_pkg::PILOT_AMP;
        res.status      = STATUS_OK;
        return res;
    endfunction

    task automatic apb_write(input logic [1:0] reg_idx,
                             input logic [crs_pkg::DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            crs_pkg::REG_CELL_ID:      cfg_shadow.cell_id      = value[8:0];
            crs_pkg::REG_NUM_RB:       cfg_shadow.num_rb       = value[6:0];
            crs_pkg::REG_NORMAL_CP:    cfg_shadow.normal_cp    = value[0];
            crs_pkg::REG_ANTENNA_PORT: cfg_shadow.antenna_port = value[1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int cell_n, input int nrb, input int cp, input int port);
        apb_write(crs_pkg::REG_CELL_ID, crs_pkg::DATA_W'(cell_n));
        apb_write(crs_pkg::REG_NUM_RB, crs_pkg::DATA_W'(nrb));
        apb_write(crs_pkg::REG_NORMAL_CP, crs_pkg::DATA_W'(cp));
        apb_write(crs_pkg::REG_ANTENNA_PORT, crs_pkg::DATA_W'(port));
    endtask

    task automatic queue_request(input int slot_n, input int sel, input int m);
        pilot_req_t rq;
        rq.slot       = 5'(slot_n);
        rq.sym_sel    = 1'(sel);
        rq.pair_index = 8'(m);
        req_items.push_back(rq);
    endtask

    task automatic queue_random(input int count);
        int nrb;
        bit nrb_ok;
        nrb    = cfg_shadow.num_rb;
        nrb_ok = nrb >= crs_pkg::NUM_RB_MIN && nrb <= MAX_RB;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 15 || !nrb_ok)
                queue_request($urandom_range(0, 31), $urandom_range(0, 1),
                              $urandom_range(0, 255));
            else
                queue_request($urandom_range(0, 19), $urandom_range(0, 1),
                              $urandom_range(0, 2 * nrb - 1));
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (req_items.size() != 0 || pilot_expected.size() != 0 || req_bus.valid);
        repeat (8) @(posedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_gap = 0;
        end
        else if (!(req_bus.valid && !req_bus.ready))
        begin
            if (req_bus.valid)
            begin
                pilot_expected.push_back(predict_pilot(cfg_shadow, req_items[0]));
                void'(req_items.pop_front());
                req_gap = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (req_gap > 0)
            begin
                req_gap--;
                req_bus.valid <= 1'b0;
            end
            else if (req_items.size() != 0)
            begin
                req_bus.valid      <= 1'b1;
                req_bus.slot       <= req_items[0].slot;
                req_bus.sym_sel    <= req_items[0].sym_sel;
                req_bus.pair_index <= req_items[0].pair_index;
            end
            else
            begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block backs up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen = 0;
        end
        else
        begin
            if (pilot_bus.valid && pilot_bus.ready)
                hold_seen++;
            if (pilot_bus.valid && pilot_bus.ready && (hold_seen == 45 || hold_seen == 130))
                hold_left <= HOLD_CYCLES;
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    // pilot monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pilot_bus.ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (pilot_bus.valid && pilot_bus.ready)
            begin
                if (pilot_expected.size() == 0)
                begin
                    log_mismatch("pilot transfer with nothing expected");
                end
                else
                begin
                    rx_want = pilot_expected.pop_front();
                    if (pilot_bus.status !== rx_want.status)
                        log_mismatch($sformatf("status got %0d want %0d",
                                               pilot_bus.status, rx_want.status));
                    if (pilot_bus.ofdm_symbol !== rx_want.ofdm_symbol)
                        log_mismatch($sformatf("ofdm_symbol got %0d want %0d",
                                               pilot_bus.ofdm_symbol, rx_want.ofdm_symbol));
                    if (pilot_bus.subcarrier !== rx_want.subcarrier)
                        log_mismatch($sformatf("subcarrier got %0d want %0d",
                                               pilot_bus.subcarrier, rx_want.subcarrier));
                    if (pilot_bus.pilot_i !== rx_want.pilot_i)
                        log_mismatch($sformatf("pilot_i got %0d want %0d",
                                               pilot_bus.pilot_i, rx_want.pilot_i));
                    if (pilot_bus.pilot_q !== rx_want.pilot_q)
                        log_mismatch($sformatf("pilot_q got %0d want %0d",
                                               pilot_bus.pilot_q, rx_want.pilot_q));
                end
                rx_count++;
                rx_gap = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (hold_left > 0)
            begin
                pilot_bus.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pilot_bus.ready <= 1'b0;
            end
            else
            begin
                pilot_bus.ready <= 1'b1;
            end
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (pilot_bus.valid && pilot_bus.ready)
            || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int cell_n, nrb;
        int bad_nrb[4];
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_bus.valid      = 1'b0;
        req_bus.slot       = '0;
        req_bus.sym_sel    = 1'b0;
        req_bus.pair_index = '0;
        pilot_bus.ready    = 1'b0;
        idle_cycles        = 0;
        bad_nrb            = '{5, 111, 127, 0};
        cfg_shadow         = '{cell_id: crs_pkg::CELL_ID_RST, num_rb: crs_pkg::NUM_RB_RST,
                               normal_cp: crs_pkg::NORMAL_CP_RST,
                               antenna_port: crs_pkg::ANTENNA_PORT_RST};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes, bad slot, index at 2*num_rb
        queue_request(0, 0, 0);
        queue_request(19, 1, 11);
        queue_request(1, 0, 5);
        queue_request(20, 0, 0);
        queue_request(31, 1, 255);
        queue_request(0, 0, 12);
        queue_request(0, 0, 255);
        wait_idle();

        set_config(503, 110, 0, 1);
        queue_request(0, 0, 0);
        queue_request(19, 1, 219);
        queue_request(7, 1, 100);
        queue_request(10, 0, 220);
        wait_idle();

        // ports 2 and 3: second reference symbol does not exist
        set_config(5, 50, 1, 2);
        queue_request(0, 0, 0);
        queue_request(1, 0, 99);
        queue_request(2, 1, 3);
        wait_idle();

        set_config(7, 25, 0, 3);
        queue_request(0, 0, 10);
        queue_request(19, 0, 49);
        queue_request(3, 1, 0);
        wait_idle();

        // cell id and resource block count out of range
        set_config(504, 6, 1, 0);
        queue_request(0, 0, 0);
        wait_idle();
        apb_write(crs_pkg::REG_CELL_ID, crs_pkg::DATA_W'(511));
        queue_request(0, 0, 0);
        wait_idle();
        apb_write(crs_pkg::REG_CELL_ID, crs_pkg::DATA_W'(0));
        foreach (bad_nrb[k])
        begin
            apb_write(crs_pkg::REG_NUM_RB, crs_pkg::DATA_W'(bad_nrb[k]));
            queue_request(0, 0, 0);
            wait_idle();
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            no_idle = (p == 3 || p == 8);
            case (p)
                1:       cell_n = 503;
                2:       cell_n = 0;
                7:       cell_n = $urandom_range(504, 511);
                default: cell_n = $urandom_range(0, 503);
            endcase
            case (p)
                1:       nrb = 110;
                2:       nrb = 6;
                5:       nrb = $urandom_range(0, 1) ? $urandom_range(0, 5)
                                                    : $urandom_range(111, 127);
                default: nrb = $urandom_range(6, 110);
            endcase
            set_config(cell_n, nrb, $urandom_range(0, 1), $urandom_range(0, 3));
            queue_random(PHASE_ITEMS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/crs_pkg.sv
rtl/crs_if.sv
rtl/crs_regs.sv
rtl/crs_ctrl.sv
rtl/crs_datapath.sv
rtl/lte_crs_pilot_generator.sv
sim/lte_crs_pilot_generator_tb.sv
